/* design/ece_pkg.sv */
package ece_pkg;

  localparam int CHANNELS_DEF      = 4;
  localparam int POSITION_BITS_DEF = 32;

  localparam int OP_W      = 2;
  localparam int CH_W      = 2;
  localparam int SAMPLE_W  = 8;
  localparam int ACC_W     = 16;
  localparam int DELTA_W   = 16;
  localparam int POS_OUT_W = 32;
  localparam int SHIFT_W   = 4;
  localparam int REV_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MASK = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] raw;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]           ch;
    logic signed [DELTA_W-1:0] delta;
    logic signed [POS_OUT_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] scale_shift;
    logic [REV_W-1:0]   reverse_mask;
  } cfg_t;

endpackage

/* design/ece_fifo.sv */
module ece_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rd_data,
  output logic                     empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             full;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/ece_front.sv */
module ece_front #(
  parameter int CHANNELS = ece_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [ece_pkg::OP_W-1:0]     opcode,
  input  logic [ece_pkg::CH_W-1:0]     channel,
  input  logic [ece_pkg::SAMPLE_W-1:0] raw_sample,
  output ece_pkg::item_t               item,
  output logic                         item_empty,
  input  logic                         item_pop
);

  import ece_pkg::*;

  localparam int ITEM_W  = $bits(item_t);
  localparam int Q_CNT_W = $clog2(MID_DEPTH + 1);

  logic             keep;
  logic             q_push;
  item_t            wr_item;
  logic [ITEM_W-1:0] rd_bits;
  logic [Q_CNT_W-1:0] q_count;

  // unused opcode and out-of-range channels are dropped here
  assign keep = ({2'b0, channel} < (CH_W + 2)'(CHANNELS)) &&
                (opcode inside {OP_INIT, OP_STEP, OP_UPDATE});

  assign wr_item.op  = opcode;
  assign wr_item.ch  = channel;
  assign wr_item.raw = raw_sample;
  assign full        = (q_count == Q_CNT_W'(MID_DEPTH));
  assign q_push      = push && keep;
  assign item        = item_t'(rd_bits);

  ece_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (wr_item),
    .pop     (item_pop),
    .rd_data (rd_bits),
    .empty   (item_empty),
    .count   (q_count)
  );

endmodule

/* design/ece_back.sv */
module ece_back #(
  parameter int CHANNELS      = ece_pkg::CHANNELS_DEF,
  parameter int POSITION_BITS = ece_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ece_pkg::cfg_t               cfg,
  input  ece_pkg::item_t              item,
  input  logic                        item_empty,
  output logic                        item_pop,
  output ece_pkg::result_t            result,
  output logic                        empty,
  input  logic                        pop
);

  import ece_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int RES_W = $bits(result_t);

  logic [SAMPLE_W-1:0]      last_sample   [CHANNELS];
  logic [ACC_W-1:0]         step_accum    [CHANNELS];
  logic [ACC_W-1:0]         last_masked   [CHANNELS];
  logic [POSITION_BITS-1:0] position_store [CHANNELS];

  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] d8;
  logic [ACC_W-1:0]    accum_next;
  logic [ACC_W-1:0]    masked_next;
  logic [ACC_W-1:0]    diff;

  // stage register between state update and scaling/position
  logic               s1_valid;
  logic [CH_W-1:0]    s1_ch;
  logic [ACC_W-1:0]   s1_diff;

  logic [IDX_W-1:0]          s1_idx;
  logic signed [DELTA_W-1:0] shifted;
  logic signed [DELTA_W-1:0] delta_val;
  logic [POSITION_BITS-1:0]  pos_next;
  result_t                   res_in;
  logic [RES_W-1:0]          res_bits;
  logic [CNT_W-1:0]          out_count;

  // only pop when the result queue has room for everything in flight
  assign item_pop = !item_empty &&
                    (({1'b0, out_count} + (CNT_W + 1)'(s1_valid)) < (CNT_W + 1)'(OUT_DEPTH));

  assign idx         = IDX_W'(item.ch);
  assign d8          = item.raw - last_sample[idx];
  assign accum_next  = step_accum[idx] + {{(ACC_W - SAMPLE_W){d8[SAMPLE_W-1]}}, d8};
  assign masked_next = accum_next & ({ACC_W{1'b1}} << cfg.scale_shift);
  assign diff        = masked_next - last_masked[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_sample[i] <= '0;
        step_accum[i]  <= '0;
        last_masked[i] <= '0;
      end
    end else if (item_pop) begin
      case (item.op)
        OP_INIT: begin
          last_sample[idx] <= item.raw;
        end
        OP_STEP: begin
          last_sample[idx] <= item.raw;
          step_accum[idx]  <= accum_next;
        end
        OP_UPDATE: begin
          last_sample[idx] <= item.raw;
          step_accum[idx]  <= accum_next;
          last_masked[idx] <= masked_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= item_pop && (item.op == OP_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    s1_ch   <= item.ch;
    s1_diff <= diff;
  end

  assign s1_idx  = IDX_W'(s1_ch);
  assign shifted = $signed(s1_diff) >>> cfg.scale_shift;

  always_comb begin
    delta_val = shifted;
    if (cfg.reverse_mask[s1_ch]) begin
      delta_val = -shifted;
    end
  end

  assign pos_next = position_store[s1_idx] + POSITION_BITS'(delta_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        position_store[i] <= '0;
      end
    end else if (s1_valid) begin
      position_store[s1_idx] <= pos_next;
    end
  end

  assign res_in.ch       = s1_ch;
  assign res_in.delta    = delta_val;
  assign res_in.position = POS_OUT_W'($signed(pos_next));
  assign result          = result_t'(res_bits);

  ece_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (s1_valid),
    .wr_data (res_in),
    .pop     (pop),
    .rd_data (res_bits),
    .empty   (empty),
    .count   (out_count)
  );

endmodule

/* design/encoder_count_extender_top.sv */
// Encoder count extender.
// Input queue side: drive opcode/channel/raw_sample and raise push; the
// transaction is taken on a clock edge with push high and full low.
// Opcode init loads the channel's last sample, step accumulates the 8-bit
// wrap difference, update also emits one result. Unused opcodes and channels
// beyond CHANNELS are taken and dropped.
// Result queue side: while empty is low, out_channel/delta/position hold the
// oldest result; pop high with empty low takes it.
// Config: cfg_valid/cfg_ready with cfg_index (0 scale_shift, 1 reverse_mask)
// and cfg_data; cfg_ready is always high. Write only while the block is idle.
// Throughput: one item per cycle while the result queue has room, set by the
// per-channel state update in the back end; a 4-entry queue decouples front
// and back. A result passes the s1 stage register before it enters the result queue.
// Reset (rst, synchronous) clears all channel state, config and both queues.
// When the receiver stalls, the result queue fills, the back end stops
// pulling, then the 4-entry input queue fills and full rises.
module encoder_count_extender_top #(
  parameter int CHANNELS      = ece_pkg::CHANNELS_DEF,
  parameter int POSITION_BITS = ece_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [ece_pkg::OP_W-1:0]             opcode,
  input  logic [ece_pkg::CH_W-1:0]             channel,
  input  logic [ece_pkg::SAMPLE_W-1:0]         raw_sample,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [ece_pkg::CH_W-1:0]             out_channel,
  output logic signed [ece_pkg::DELTA_W-1:0]   delta,
  output logic signed [ece_pkg::POS_OUT_W-1:0] position,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ece_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ece_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import ece_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_empty;
  logic    item_pop;
  result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE_SHIFT:  cfg.scale_shift  <= cfg_data[SHIFT_W-1:0];
        CFG_REVERSE_MASK: cfg.reverse_mask <= cfg_data[REV_W-1:0];
        default: ;
      endcase
    end
  end

  ece_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .channel    (channel),
    .raw_sample (raw_sample),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop)
  );

  ece_back #(
    .CHANNELS      (CHANNELS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

  assign out_channel = result.ch;
  assign delta       = result.delta;
  assign position    = result.position;

endmodule

/* sim/tb_encoder_count_extender_top.sv */
module tb_encoder_count_extender_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ece_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [OP_W-1:0] opcode = '0;
  logic [CH_W-1:0] channel = '0;
  logic [SAMPLE_W-1:0] raw_sample = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CH_W-1:0] out_channel;
  logic signed [DELTA_W-1:0] delta;
  logic signed [POS_OUT_W-1:0] position;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  encoder_count_extender_top uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .opcode(opcode), .channel(channel), .raw_sample(raw_sample),
    .empty(empty), .pop(pop),
    .out_channel(out_channel), .delta(delta), .position(position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [SAMPLE_W-1:0] last_raw [NCH];
  logic [ACC_W-1:0] accum [NCH];
  logic [ACC_W-1:0] prev_masked [NCH];
  logic [POS_OUT_W-1:0] pos_acc [NCH];
  logic [SHIFT_W-1:0] shift_cfg = '0;
  logic [REV_W-1:0] rev_cfg = '0;

  item_t sample_q [$];
  result_t predicted_moves [$];
  item_t nxt;
  logic [SAMPLE_W-1:0] gen_last [NCH];

  int idle_pct = 9;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;
  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int settings_used = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic track_encoder(input item_t it);
    logic [SAMPLE_W-1:0] d8;
    logic [ACC_W-1:0] now;
    logic [ACC_W-1:0] d;
    result_t r;
    if (it.op == OP_INIT) begin
      last_raw[it.ch] = it.raw;
    end else if (it.op == OP_STEP || it.op == OP_UPDATE) begin
      d8 = it.raw - last_raw[it.ch];
      last_raw[it.ch] = it.raw;
      accum[it.ch] = accum[it.ch] + {{(ACC_W-SAMPLE_W){d8[SAMPLE_W-1]}}, d8};
      if (it.op == OP_UPDATE) begin
        now = accum[it.ch] & (16'hffff << shift_cfg);
        d = now - prev_masked[it.ch];
        d = $signed(d) >>> shift_cfg;
        if (rev_cfg[it.ch]) d = 16'd0 - d;
        prev_masked[it.ch] = now;
        pos_acc[it.ch] = pos_acc[it.ch] + {{(POS_OUT_W-DELTA_W){d[DELTA_W-1]}}, d};
        r.ch = it.ch;
        r.delta = d;
        r.position = pos_acc[it.ch];
        predicted_moves.push_back(r);
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        track_encoder('{op: opcode, ch: channel, raw: raw_sample});
        items_taken++;
      end
      if (push && full) stall_cycles++;
      if (!push || !full) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = sample_q.pop_front();
          push <= 1'b1;
          opcode <= nxt.op;
          channel <= nxt.ch;
          raw_sample <= nxt.raw;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (predicted_moves.size() == 0) begin
          flag($sformatf("unexpected result ch=%0d delta=%0d pos=%0d",
                         out_channel, delta, position));
        end else begin
          r = predicted_moves.pop_front();
          if (out_channel !== r.ch)
            flag($sformatf("channel got %0d want %0d", out_channel, r.ch));
          if (delta !== r.delta)
            flag($sformatf("delta ch%0d got %0d want %0d", r.ch, delta, r.delta));
          if (position !== r.position)
            flag($sformatf("position ch%0d got %0d want %0d", r.ch, position,
                           r.position));
        end
      end
      pop <= !hold_off && ($urandom_range(99) >= idle_pct);
    end
  end

  // long receiver hold-off to back up both queues
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCALE_SHIFT) shift_cfg = val;
    else if (idx == CFG_REVERSE_MASK) rev_cfg = val;
  endtask

  task automatic configure(input logic [SHIFT_W-1:0] sh, input logic [REV_W-1:0] rv);
    write_reg(CFG_SCALE_SHIFT, sh);
    write_reg(CFG_REVERSE_MASK, rv);
    settings_used++;
  endtask

  task automatic settle();
    while (sample_q.size() != 0 || push || predicted_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                          input logic [SAMPLE_W-1:0] raw);
    sample_q.push_back('{op: op, ch: ch, raw: raw});
    if (op != OP_UNUSED) gen_last[ch] = raw;
  endtask

  // mostly plausible encoder motion, with jumps, re-inits and unused opcodes
  task automatic add_random(input int n, input int upd_pct);
    int r;
    logic [CH_W-1:0] ch;
    logic [SAMPLE_W-1:0] raw;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      ch = CH_W'($urandom_range(NCH - 1));
      if ($urandom_range(1)) raw = gen_last[ch] + 8'($signed($urandom_range(12)) - 6);
      else raw = SAMPLE_W'($urandom_range(255));
      if (r < 4) add_item(OP_UNUSED, ch, SAMPLE_W'($urandom_range(255)));
      else if (r < 10) add_item(OP_INIT, ch, raw);
      else if ($urandom_range(99) < upd_pct) add_item(OP_UPDATE, ch, raw);
      else add_item(OP_STEP, ch, raw);
    end
  endtask

  // 256 steps of -128 move the accumulator by exactly 0x8000
  task automatic add_wrap_run(input logic [CH_W-1:0] ch);
    add_item(OP_UPDATE, ch, gen_last[ch]);
    for (int i = 0; i < 255; i++) add_item(OP_STEP, ch, gen_last[ch] ^ 8'h80);
    add_item(OP_UPDATE, ch, gen_last[ch] ^ 8'h80);
  endtask

  initial begin
    for (int c = 0; c < NCH; c++) begin
      last_raw[c] = '0;
      accum[c] = '0;
      prev_masked[c] = '0;
      pos_acc[c] = '0;
      gen_last[c] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: wrap differences, unused opcode, all channels
    configure(4'd0, 4'd0);
    add_item(OP_INIT, 2'd0, 8'hff);
    add_item(OP_STEP, 2'd0, 8'h00);
    add_item(OP_STEP, 2'd0, 8'h80);
    add_item(OP_STEP, 2'd0, 8'hff);
    add_item(OP_UPDATE, 2'd0, 8'hff);
    add_item(OP_UPDATE, 2'd0, 8'h7e);
    add_item(OP_UPDATE, 2'd1, 8'h80);
    add_item(OP_UNUSED, 2'd2, 8'hff);
    add_item(OP_UPDATE, 2'd2, 8'haa);
    add_item(OP_INIT, 2'd3, 8'h55);
    add_item(OP_UPDATE, 2'd3, 8'h55);
    add_item(OP_UPDATE, 2'd3, 8'hd4);
    settle();

    // largest shift, mixed reversal
    configure(4'd15, 4'b1010);
    add_item(OP_UPDATE, 2'd0, 8'h00);
    add_item(OP_UPDATE, 2'd1, 8'h7f);
    add_item(OP_UPDATE, 2'd2, 8'h80);
    add_item(OP_UPDATE, 2'd3, 8'hff);
    settle();

    configure(4'd8, 4'hf);
    add_item(OP_UPDATE, 2'd0, 8'h7f);
    add_item(OP_UPDATE, 2'd1, 8'h00);
    add_item(OP_UPDATE, 2'd2, 8'hff);
    add_item(OP_UPDATE, 2'd3, 8'h80);
    settle();

    configure(4'd3, 4'd0);
    add_random(60, 40);
    settle();

    // receiver stalls while the sender keeps pushing
    configure(4'd8, 4'hf);
    hold_go = 1'b1;
    add_random(120, 85);
    settle();

    // no idling; negating the most negative delta
    idle_pct = 0;
    configure(4'd0, 4'hf);
    add_wrap_run(CH_W'($urandom_range(NCH - 1)));
    add_random(40, 50);
    settle();
    idle_pct = 9;

    configure(4'd1, 4'h5);
    add_random(60, 50);
    settle();

    configure(4'd9, 4'h3);
    add_random(40, 50);
    settle();

    repeat (3) begin
      configure(SHIFT_W'($urandom_range(15)), REV_W'($urandom_range(15)));
      add_random(40, 50);
      settle();
    end

    $display("%0d transactions in, %0d results checked over %0d register settings",
             items_taken, results_seen, settings_used);
    $display("input held off by a full queue for %0d cycles", stall_cycles);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
